// ----- rtl/core/tog_pkg.sv -----
// tog_pkg: shared constants for the oldest-first ticket grant block
// op and status codes, parameter defaults; no dependencies
`default_nettype none

package tog_pkg;

  // parameter defaults
  localparam int DEF_SLOTS       = 32;
  localparam int DEF_TICKET_BITS = 16;

  // op codes of an input transfer
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_GRANT   = 2'd2;

  // status codes of a result transfer
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SHORT     = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/core/tog_ram.sv -----
// tog_ram: generic single-write, single-read ram with registered read data
// no package dependency
`default_nettype none

module tog_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/ticket_oldest_three_grant.sv -----
// ticket_oldest_three_grant: oldest-first ticket arbiter, top level
// depends on tog_pkg (codes, defaults) and tog_ram (slot ticket store)
`default_nettype none

// channel   direction  handshake              payload
// in_       input      in_valid / in_stall    in_op, in_requester
// out_      output     out_valid / out_stall  out_status, out_ticket,
//                                             out_grant_first/second/third
//
// request and release need no scan; a grant reads the ticket ram one slot a
// cycle, so the input is stalled after the grant transfer until the scan ends;
// the output register is loaded at the last scan edge if it is free, else the
// result goes to the holding register; the scan is bounded by the ram read port
// reset clears the pending flags and the ticket counter at once, no sweep
// a result waits in a holding register while the output register is stalled;
// the input is stalled during a grant scan and while that holding register is full

module ticket_oldest_three_grant #(
  parameter int SLOTS       = tog_pkg::DEF_SLOTS,
  parameter int TICKET_BITS = tog_pkg::DEF_TICKET_BITS,
  localparam int SLOT_W     = $clog2(SLOTS)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             in_op,
  input  wire logic [SLOT_W-1:0]      in_requester,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [1:0]                  out_status,
  output logic [TICKET_BITS-1:0]      out_ticket,
  output logic [SLOT_W-1:0]           out_grant_first,
  output logic [SLOT_W-1:0]           out_grant_second,
  output logic [SLOT_W-1:0]           out_grant_third
);

  localparam int TB = TICKET_BITS;

  // all-ones is the never-issued sentinel, so the last ticket is one below
  localparam logic [TB-1:0]     TICKET_LAST = {{(TB-1){1'b1}}, 1'b0};
  localparam logic [TB-1:0]     TICKET_ONE  = {{(TB-1){1'b0}}, 1'b1};
  localparam logic [SLOT_W:0]   SLOT_COUNT  = (SLOT_W+1)'(SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_LAST   = SLOT_W'(SLOTS - 1);
  localparam logic [SLOT_W-1:0] SLOT_ONE    = {{(SLOT_W-1){1'b0}}, 1'b1};

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [TB-1:0]     ticket_cnt_r, ticket_cnt_nxt;
  // one pending flag per slot; a clear flag keeps the slot out of the scan
  logic [SLOTS-1:0]  pend_r, pend_nxt;

  // three oldest seen so far during a scan, kept in ascending ticket order
  logic [TB-1:0]     best_tk_r  [3];
  logic [TB-1:0]     best_tk_nxt[3];
  logic [SLOT_W-1:0] best_sl_r  [3];
  logic [SLOT_W-1:0] best_sl_nxt[3];
  logic              best_ok_r  [3];
  logic              best_ok_nxt[3];

  // holding register for a result that found the output register stalled
  logic [1:0]        res_status_r, res_status_nxt;
  logic [TB-1:0]     res_ticket_r, res_ticket_nxt;
  logic [SLOT_W-1:0] res_g0_r, res_g0_nxt;
  logic [SLOT_W-1:0] res_g1_r, res_g1_nxt;
  logic [SLOT_W-1:0] res_g2_r, res_g2_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [TB-1:0]     out_ticket_r, out_ticket_nxt;
  logic [SLOT_W-1:0] out_g0_r, out_g0_nxt;
  logic [SLOT_W-1:0] out_g1_r, out_g1_nxt;
  logic [SLOT_W-1:0] out_g2_r, out_g2_nxt;

  // ticket ram ports
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [TB-1:0]     ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  logic [TB-1:0]     ram_rdata;

  logic              accept;
  logic              out_ready;
  logic              in_range;
  logic [TB-1:0]     ticket_inc;
  logic              cand_pend;
  logic              lt0, lt1, lt2;

  // result produced this cycle
  logic              prod;
  logic [1:0]        p_status;
  logic [TB-1:0]     p_ticket;
  logic [SLOT_W-1:0] p_g0, p_g1, p_g2;

  tog_ram #(
    .WIDTH(TB),
    .DEPTH(SLOTS)
  ) u_ticket_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign out_ready = !out_valid_r || !out_stall;
  assign in_range  = ({1'b0, in_requester} < SLOT_COUNT);
  assign ticket_inc = ticket_cnt_r + TICKET_ONE;

  // candidate from the ram this scan cycle; strict compares keep lowest slot
  assign cand_pend = pend_r[scan_idx_r];
  assign lt0 = !best_ok_r[0] || (ram_rdata < best_tk_r[0]);
  assign lt1 = !best_ok_r[1] || (ram_rdata < best_tk_r[1]);
  assign lt2 = !best_ok_r[2] || (ram_rdata < best_tk_r[2]);

  always_comb begin
    state_nxt      = state_r;
    scan_idx_nxt   = scan_idx_r;
    ticket_cnt_nxt = ticket_cnt_r;
    pend_nxt       = pend_r;
    best_tk_nxt    = best_tk_r;
    best_sl_nxt    = best_sl_r;
    best_ok_nxt    = best_ok_r;
    res_status_nxt = res_status_r;
    res_ticket_nxt = res_ticket_r;
    res_g0_nxt     = res_g0_r;
    res_g1_nxt     = res_g1_r;
    res_g2_nxt     = res_g2_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_ticket_nxt = out_ticket_r;
    out_g0_nxt     = out_g0_r;
    out_g1_nxt     = out_g1_r;
    out_g2_nxt     = out_g2_r;

    ram_we    = 1'b0;
    ram_waddr = in_requester;
    ram_wdata = ticket_inc;
    ram_raddr = (scan_idx_r == SLOT_LAST) ? '0 : scan_idx_r + SLOT_ONE;

    prod     = 1'b0;
    p_status = tog_pkg::ST_OK;
    p_ticket = '0;
    p_g0     = '0;
    p_g1     = '0;
    p_g2     = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          prod = 1'b1;
          case (in_op)
            tog_pkg::OP_REQUEST: begin
              if (in_range) begin
                if (ticket_cnt_r >= TICKET_LAST) begin
                  p_status = tog_pkg::ST_EXHAUSTED;
                end else begin
                  ticket_cnt_nxt         = ticket_inc;
                  ram_we                 = 1'b1;
                  pend_nxt[in_requester] = 1'b1;
                  p_ticket               = ticket_inc;
                end
              end
            end
            tog_pkg::OP_RELEASE: begin
              if (in_range) begin
                pend_nxt[in_requester] = 1'b0;
              end
            end
            tog_pkg::OP_GRANT: begin
              // start the scan: slot 0 data appears next cycle
              prod         = 1'b0;
              state_nxt    = S_SCAN;
              scan_idx_nxt = '0;
              ram_raddr    = '0;
              best_ok_nxt  = '{1'b0, 1'b0, 1'b0};
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (cand_pend && lt0) begin
          best_tk_nxt = '{ram_rdata, best_tk_r[0], best_tk_r[1]};
          best_sl_nxt = '{scan_idx_r, best_sl_r[0], best_sl_r[1]};
          best_ok_nxt = '{1'b1, best_ok_r[0], best_ok_r[1]};
        end else if (cand_pend && lt1) begin
          best_tk_nxt = '{best_tk_r[0], ram_rdata, best_tk_r[1]};
          best_sl_nxt = '{best_sl_r[0], scan_idx_r, best_sl_r[1]};
          best_ok_nxt = '{1'b1, 1'b1, best_ok_r[1]};
        end else if (cand_pend && lt2) begin
          best_tk_nxt[2] = ram_rdata;
          best_sl_nxt[2] = scan_idx_r;
          best_ok_nxt[2] = 1'b1;
        end
        scan_idx_nxt = scan_idx_r + SLOT_ONE;
        if (scan_idx_r == SLOT_LAST) begin
          state_nxt = S_IDLE;
          prod      = 1'b1;
          if (best_ok_nxt[2]) begin
            p_g0 = best_sl_nxt[0];
            p_g1 = best_sl_nxt[1];
            p_g2 = best_sl_nxt[2];
          end else begin
            p_status = tog_pkg::ST_SHORT;
          end
        end
      end
      S_WAIT: begin
        if (out_ready) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_ticket_nxt = res_ticket_r;
          out_g0_nxt     = res_g0_r;
          out_g1_nxt     = res_g1_r;
          out_g2_nxt     = res_g2_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // new result goes straight out if the output register frees up
    if (prod) begin
      if (out_ready) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = p_status;
        out_ticket_nxt = p_ticket;
        out_g0_nxt     = p_g0;
        out_g1_nxt     = p_g1;
        out_g2_nxt     = p_g2;
      end else begin
        state_nxt      = S_WAIT;
        res_status_nxt = p_status;
        res_ticket_nxt = p_ticket;
        res_g0_nxt     = p_g0;
        res_g1_nxt     = p_g1;
        res_g2_nxt     = p_g2;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ticket_cnt_r <= '0;
      pend_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ticket_cnt_r <= ticket_cnt_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    scan_idx_r   <= scan_idx_nxt;
    best_tk_r    <= best_tk_nxt;
    best_sl_r    <= best_sl_nxt;
    best_ok_r    <= best_ok_nxt;
    res_status_r <= res_status_nxt;
    res_ticket_r <= res_ticket_nxt;
    res_g0_r     <= res_g0_nxt;
    res_g1_r     <= res_g1_nxt;
    res_g2_r     <= res_g2_nxt;
    out_status_r <= out_status_nxt;
    out_ticket_r <= out_ticket_nxt;
    out_g0_r     <= out_g0_nxt;
    out_g1_r     <= out_g1_nxt;
    out_g2_r     <= out_g2_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_ticket       = out_ticket_r;
  assign out_grant_first  = out_g0_r;
  assign out_grant_second = out_g1_r;
  assign out_grant_third  = out_g2_r;

endmodule

`default_nettype wire
